// ===== src/lru_block_buffer_cache_core_assert.svh =====
// ----------------------------------------------------------------------------
// LRU block buffer cache assertion macros
// Shared assertion forms for the port checker, clocked on clk and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_BUFFER_CACHE_CORE_ASSERT_SVH
`define LRU_BLOCK_BUFFER_CACHE_CORE_ASSERT_SVH

// Same-cycle implication.
`define LBBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbbc port check failed");

// Next-cycle implication.
`define LBBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbbc port check failed");

`endif

// ===== src/lbbc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU block buffer cache package
// Field widths, action codes and result kinds shared by the cache files.
// ----------------------------------------------------------------------------
package lbbc_pkg;

    localparam int ACTION_W   = 3;
    localparam int KIND_W     = 2;
    localparam int BN_W       = 16;
    localparam int SLOT_OUT_W = 3;

    typedef logic [ACTION_W-1:0]   action_t;
    typedef logic [KIND_W-1:0]     kind_t;
    typedef logic [BN_W-1:0]       block_num_t;
    typedef logic [SLOT_OUT_W-1:0] slot_out_t;

    localparam action_t ACT_BLOCK  = 3'd0;
    localparam action_t ACT_BUFFER = 3'd1;
    localparam action_t ACT_UPDATE = 3'd2;
    localparam action_t ACT_SAVE   = 3'd3;
    localparam action_t ACT_FLUSH  = 3'd4;
    localparam action_t ACT_EMPTY  = 3'd5;

    localparam kind_t KIND_WB    = 2'd0;
    localparam kind_t KIND_LOAD  = 2'd1;
    localparam kind_t KIND_GRANT = 2'd2;
    localparam kind_t KIND_DONE  = 2'd3;

endpackage

// ===== src/lbbc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/lru_block_buffer_cache_core.sv =====
// ----------------------------------------------------------------------------
// LRU block buffer cache core
// Fully associative write-back cache of block numbers with LRU replacement.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  request   start, busy             action, block_number
//  result    result_valid (strobe)   kind, slot, block_number_out, last
//
// A lookup reads one slot tag per cycle from the tag RAM through a single
// comparator. A hit goes from the scan straight to the grant; a miss passes
// through the miss state, a write-back state when the victim is valid and
// dirty, and the assign state before the grant. Save and flush sweep every
// slot; update, empty and unused actions go straight to the done state. Busy
// falls at the edge that puts the final beat on the result ports. Reset clears
// all valid and dirty bits and restores the recency order; the tag RAM is not
// cleared. The result side cannot stall, so each beat is shown for one cycle only.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_core #(
    parameter int NUM_SLOTS  = 8,
    parameter int BLOCK_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  lbbc_pkg::action_t      action,
    input  lbbc_pkg::block_num_t   block_number,
    output logic                   result_valid,
    output lbbc_pkg::kind_t        kind,
    output lbbc_pkg::slot_out_t    slot,
    output lbbc_pkg::block_num_t   block_number_out,
    output logic                   last
);

    import lbbc_pkg::*;

    localparam int SW     = (BLOCK_BITS < BN_W) ? BLOCK_BITS : BN_W;
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = SLOT_W + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0]  SLOT_CNT  = CNT_W'(NUM_SLOTS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_MISS   = 3'd2;
    localparam logic [2:0] S_WB     = 3'd3;
    localparam logic [2:0] S_ASSIGN = 3'd4;
    localparam logic [2:0] S_GRANT  = 3'd5;
    localparam logic [2:0] S_SWEEP  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]        state_reg, state_next;
    action_t           action_reg, action_next;
    logic [SW-1:0]     blk_reg, blk_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] pend_idx_reg, pend_idx_next;
    logic [SLOT_W-1:0] pend_rank_reg, pend_rank_next;
    logic [SLOT_W-1:0] vict_reg, vict_next;
    logic [SLOT_W-1:0] sel_reg, sel_next;
    logic [SLOT_W-1:0] sel_rank_reg, sel_rank_next;

    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [NUM_SLOTS-1:0] dirty_reg, dirty_next;
    logic [SLOT_W-1:0]    rank_reg [NUM_SLOTS];
    logic [SLOT_W-1:0]    rank_next [NUM_SLOTS];
    logic                 cur_valid_reg, cur_valid_next;
    logic [SLOT_W-1:0]    cur_slot_reg, cur_slot_next;

    logic              rv_reg, rv_next;
    logic              last_reg, last_next;
    kind_t             kind_reg, kind_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SW-1:0]     bno_reg, bno_next;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_raddr;
    logic [SW-1:0]     ram_rdata;
    logic [SLOT_W-1:0] idx_lo;
    logic              issuing;

    lbbc_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (vict_reg),
        .wdata (blk_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_lo  = idx_reg[SLOT_W-1:0];
    assign issuing = (idx_reg < SLOT_CNT);

    always_comb
    begin
        state_next     = state_reg;
        action_next    = action_reg;
        blk_next       = blk_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        pend_rank_next = pend_rank_reg;
        vict_next      = vict_reg;
        sel_next       = sel_reg;
        sel_rank_next  = sel_rank_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        rank_next      = rank_reg;
        cur_valid_next = cur_valid_reg;
        cur_slot_next  = cur_slot_reg;
        rv_next        = 1'b0;
        last_next      = 1'b0;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        bno_next       = bno_reg;
        ram_we         = 1'b0;
        ram_raddr      = idx_lo;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    action_next = action;
                    blk_next    = block_number[SW-1:0];
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    if (action == ACT_BLOCK || action == ACT_BUFFER)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (action == ACT_SAVE || action == ACT_FLUSH)
                    begin
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_SCAN:
            begin
                pend_next = issuing;
                if (issuing)
                begin
                    idx_next       = idx_reg + 1'b1;
                    pend_idx_next  = idx_lo;
                    pend_rank_next = rank_reg[idx_lo];
                    if (rank_reg[idx_lo] == '0)
                    begin
                        vict_next = idx_lo;
                    end
                end
                if (pend_reg)
                begin
                    if (valid_reg[pend_idx_reg] && ram_rdata == blk_reg)
                    begin
                        sel_next      = pend_idx_reg;
                        sel_rank_next = pend_rank_reg;
                        pend_next     = 1'b0;
                        state_next    = S_GRANT;
                    end
                    else if (pend_idx_reg == LAST_SLOT)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_MISS;
                    end
                end
            end

            S_MISS:
            begin
                ram_raddr     = vict_reg;
                sel_next      = vict_reg;
                sel_rank_next = '0;
                if (valid_reg[vict_reg] && dirty_reg[vict_reg])
                begin
                    state_next = S_WB;
                end
                else
                begin
                    state_next = S_ASSIGN;
                end
            end

            S_WB:
            begin
                rv_next              = 1'b1;
                kind_next            = KIND_WB;
                slot_next            = vict_reg;
                bno_next             = ram_rdata;
                dirty_next[vict_reg] = 1'b0;
                state_next           = S_ASSIGN;
            end

            S_ASSIGN:
            begin
                ram_we               = 1'b1;
                valid_next[vict_reg] = 1'b1;
                dirty_next[vict_reg] = 1'b0;
                if (action_reg == ACT_BLOCK)
                begin
                    rv_next   = 1'b1;
                    kind_next = KIND_LOAD;
                    slot_next = vict_reg;
                    bno_next  = blk_reg;
                end
                state_next = S_GRANT;
            end

            S_GRANT:
            begin
                cur_valid_next = 1'b1;
                cur_slot_next  = sel_reg;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (rank_reg[i] > sel_rank_reg)
                    begin
                        rank_next[i] = rank_reg[i] - 1'b1;
                    end
                end
                rank_next[sel_reg] = LAST_SLOT;
                rv_next    = 1'b1;
                last_next  = 1'b1;
                kind_next  = KIND_GRANT;
                slot_next  = sel_reg;
                bno_next   = blk_reg;
                state_next = S_IDLE;
            end

            S_SWEEP:
            begin
                pend_next = 1'b0;
                if (issuing)
                begin
                    idx_next      = idx_reg + 1'b1;
                    pend_next     = valid_reg[idx_lo] && dirty_reg[idx_lo];
                    pend_idx_next = idx_lo;
                end
                if (pend_reg)
                begin
                    rv_next                  = 1'b1;
                    kind_next                = KIND_WB;
                    slot_next                = pend_idx_reg;
                    bno_next                 = ram_rdata;
                    dirty_next[pend_idx_reg] = 1'b0;
                end
                else if (!issuing)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                case (action_reg)
                    ACT_UPDATE:
                    begin
                        if (cur_valid_reg)
                        begin
                            dirty_next[cur_slot_reg] = 1'b1;
                        end
                    end
                    ACT_FLUSH:
                    begin
                        valid_next     = '0;
                        dirty_next     = '0;
                        cur_valid_next = 1'b0;
                        cur_slot_next  = '0;
                    end
                    ACT_EMPTY:
                    begin
                        valid_next     = '0;
                        dirty_next     = '0;
                        cur_valid_next = 1'b0;
                        cur_slot_next  = '0;
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            rank_next[i] = SLOT_W'(i);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                rv_next    = 1'b1;
                last_next  = 1'b1;
                kind_next  = KIND_DONE;
                slot_next  = '0;
                bno_next   = '0;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_slot_reg  <= '0;
            rv_reg        <= 1'b0;
            last_reg      <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                rank_reg[i] <= SLOT_W'(i);
            end
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            cur_valid_reg <= cur_valid_next;
            cur_slot_reg  <= cur_slot_next;
            rv_reg        <= rv_next;
            last_reg      <= last_next;
            rank_reg      <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        blk_reg       <= blk_next;
        pend_idx_reg  <= pend_idx_next;
        pend_rank_reg <= pend_rank_next;
        vict_reg      <= vict_next;
        sel_reg       <= sel_next;
        sel_rank_reg  <= sel_rank_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        bno_reg       <= bno_next;
    end

    assign busy             = (state_reg != S_IDLE);
    assign result_valid     = rv_reg;
    assign last             = last_reg;
    assign kind             = kind_reg;
    assign slot             = SLOT_OUT_W'(slot_reg);
    assign block_number_out = BN_W'(bno_reg);

endmodule

// ===== src/lbbc_checker.sv =====
// ----------------------------------------------------------------------------
// LRU block buffer cache port checker
// Watches the request and result ports of the cache core over time.
// ----------------------------------------------------------------------------
`include "lru_block_buffer_cache_core_assert.svh"

module lbbc_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   result_valid,
    input lbbc_pkg::kind_t        kind,
    input lbbc_pkg::slot_out_t    slot,
    input lbbc_pkg::block_num_t   block_number_out,
    input logic                   last
);

    import lbbc_pkg::*;

    // An accepted request always keeps the core busy in the following cycle.
    `LBBC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // The final beat of a request appears only once the core is free again.
    `LBBC_ASSERT_NOW(a_last_idle, result_valid && last, !busy)

    // Any beat that is not the final one belongs to a request still running.
    `LBBC_ASSERT_NOW(a_mid_busy, result_valid && !last, busy)

    // A done beat is always the final one and carries no slot or block.
    `LBBC_ASSERT_NOW(a_done_form, result_valid && kind == KIND_DONE,
        last && slot == '0 && block_number_out == '0)

endmodule

bind lru_block_buffer_cache_core lbbc_checker u_lbbc_checker (.*);

// ===== bench/tb_lru_block_buffer_cache_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU block buffer cache core testbench
// Drives block, buffer, update, save, flush, empty and unused-code requests into the core.
// A scoreboard class keeps its own copy of the slot tags, valid and dirty bits,
// recency order and current slot, and predicts every result beat. Each strobed
// beat is then checked field by field against the oldest prediction. The run
// starts with a short directed sequence and goes on with random traffic, mostly on a
// small pool of block numbers, so that hits, evictions and write-backs are common.
// ----------------------------------------------------------------------------
module tb_lru_block_buffer_cache_core;
    import lbbc_pkg::*;

    localparam int NSLOTS = 8;
    localparam int POOL_SIZE = 12;
    localparam int RANDOM_ITEMS = 250;
    localparam int CALM_TAIL = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam action_t ACT_RSVD_LO = 3'd6;
    localparam action_t ACT_RSVD_HI = 3'd7;

    typedef struct packed {
        kind_t      kind;
        slot_out_t  slot_idx;
        block_num_t bnum;
        logic       is_last;
    } beat_t;

    class cache_scoreboard;
        block_num_t  tag_q[NSLOTS];
        bit          valid_q[NSLOTS];
        bit          dirty_q[NSLOTS];
        int unsigned rank_q[NSLOTS];
        bit          cur_valid;
        int unsigned cur_slot;
        beat_t       expected_beats[$];
        int          errors;
        int          requests;
        int          loads;
        int          writebacks;
        int          hits;
        int          beats_seen;

        function new();
            foreach (tag_q[i]) tag_q[i] = '0;
            invalidate();
            restore_order();
        endfunction

        function void invalidate();
            foreach (valid_q[i])
            begin
                valid_q[i] = 1'b0;
                dirty_q[i] = 1'b0;
            end
            cur_valid = 1'b0;
            cur_slot = 0;
        endfunction

        function void restore_order();
            foreach (rank_q[i]) rank_q[i] = i;
        endfunction

        function void push_beat(kind_t k, int unsigned s, block_num_t bn, bit is_last);
            beat_t b;
            b.kind = k;
            b.slot_idx = slot_out_t'(s);
            b.bnum = bn;
            b.is_last = is_last;
            expected_beats.push_back(b);
        endfunction

        function void write_back_dirty();
            for (int i = 0; i < NSLOTS; i++)
            begin
                if (valid_q[i] && dirty_q[i])
                begin
                    push_beat(KIND_WB, i, tag_q[i], 1'b0);
                    dirty_q[i] = 1'b0;
                    writebacks++;
                end
            end
        endfunction

        function int unsigned lru_slot();
            for (int i = 0; i < NSLOTS; i++)
                if (rank_q[i] == 0) return i;
            return 0;
        endfunction

        function void promote(int unsigned s);
            int unsigned r;
            r = rank_q[s];
            for (int i = 0; i < NSLOTS; i++)
                if (rank_q[i] > r) rank_q[i]--;
            rank_q[s] = NSLOTS - 1;
        endfunction

        function void note_request(action_t act, block_num_t bn);
            bit hit;
            int unsigned s;
            hit = 1'b0;
            s = 0;
            requests++;
            case (act)
                ACT_BLOCK, ACT_BUFFER:
                begin
                    for (int i = 0; i < NSLOTS; i++)
                    begin
                        if (!hit && valid_q[i] && tag_q[i] == bn)
                        begin
                            hit = 1'b1;
                            s = i;
                        end
                    end
                    if (hit)
                        hits++;
                    else
                    begin
                        s = lru_slot();
                        if (valid_q[s] && dirty_q[s])
                        begin
                            push_beat(KIND_WB, s, tag_q[s], 1'b0);
                            writebacks++;
                        end
                        tag_q[s] = bn;
                        valid_q[s] = 1'b1;
                        dirty_q[s] = 1'b0;
                        if (act == ACT_BLOCK)
                        begin
                            push_beat(KIND_LOAD, s, bn, 1'b0);
                            loads++;
                        end
                    end
                    cur_valid = 1'b1;
                    cur_slot = s;
                    promote(s);
                    push_beat(KIND_GRANT, s, bn, 1'b1);
                end
                ACT_UPDATE:
                begin
                    if (cur_valid) dirty_q[cur_slot] = 1'b1;
                    push_beat(KIND_DONE, 0, '0, 1'b1);
                end
                ACT_SAVE:
                begin
                    write_back_dirty();
                    push_beat(KIND_DONE, 0, '0, 1'b1);
                end
                ACT_FLUSH:
                begin
                    write_back_dirty();
                    invalidate();
                    push_beat(KIND_DONE, 0, '0, 1'b1);
                end
                ACT_EMPTY:
                begin
                    invalidate();
                    restore_order();
                    push_beat(KIND_DONE, 0, '0, 1'b1);
                end
                default:
                    push_beat(KIND_DONE, 0, '0, 1'b1);
            endcase
        endfunction

        function void check_beat(kind_t k, slot_out_t s, block_num_t bn, logic is_last);
            beat_t e;
            beats_seen++;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat: kind %0d, slot %0d, block_number_out %0d, last %0d",
                       k, s, bn, is_last);
                errors++;
                return;
            end
            e = expected_beats.pop_front();
            if (k !== e.kind)
            begin
                $error("kind mismatch: expected %0d, actual %0d", e.kind, k);
                errors++;
            end
            if (s !== e.slot_idx)
            begin
                $error("slot mismatch: expected %0d, actual %0d", e.slot_idx, s);
                errors++;
            end
            if (bn !== e.bnum)
            begin
                $error("block_number_out mismatch: expected %0d, actual %0d", e.bnum, bn);
                errors++;
            end
            if (is_last !== e.is_last)
            begin
                $error("last mismatch: expected %0d, actual %0d", e.is_last, is_last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    action_t    action;
    block_num_t block_number;
    logic       result_valid;
    kind_t      kind;
    slot_out_t  slot;
    block_num_t block_number_out;
    logic       last;

    cache_scoreboard sb;
    block_num_t      bn_pool[POOL_SIZE];

    lru_block_buffer_cache_core #(
        .NUM_SLOTS  (NSLOTS),
        .BLOCK_BITS (16)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .action           (action),
        .block_number     (block_number),
        .result_valid     (result_valid),
        .kind             (kind),
        .slot             (slot),
        .block_number_out (block_number_out),
        .last             (last)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy) sb.note_request(action, block_number);
            if (result_valid) sb.check_beat(kind, slot, block_number_out, last);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles.", CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_request(action_t act, block_num_t bn);
        start <= 1'b1;
        action <= act;
        block_number <= bn;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic idle_for(int n);
        start <= 1'b0;
        action <= action_t'($urandom);
        block_number <= block_num_t'($urandom);
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_until_drained();
        int guard;
        guard = 0;
        start <= 1'b0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (sb.pending() != 0 && guard < 20000);
    endtask

    function automatic action_t pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return ACT_BLOCK;
        if (r < 55) return ACT_BUFFER;
        if (r < 78) return ACT_UPDATE;
        if (r < 86) return ACT_SAVE;
        if (r < 91) return ACT_FLUSH;
        if (r < 95) return ACT_EMPTY;
        if (r < 97) return ACT_RSVD_LO;
        return ACT_RSVD_HI;
    endfunction

    function automatic block_num_t pick_block();
        if ($urandom_range(0, 4) == 0) return block_num_t'($urandom_range(0, 65535));
        return bn_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    initial
    begin
        bit calm;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_UPDATE;
        block_number = '0;
        calm = 1'b0;
        foreach (bn_pool[i]) bn_pool[i] = block_num_t'($urandom_range(0, 65535));
        bn_pool[0] = 16'h0000;
        bn_pool[1] = 16'hFFFF;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(ACT_UPDATE, 16'h5A5A);
        send_request(ACT_BLOCK, 16'h0000);
        send_request(ACT_UPDATE, 16'h0000);
        send_request(ACT_BLOCK, 16'hFFFF);
        send_request(ACT_UPDATE, 16'hFFFF);
        send_request(ACT_BUFFER, 16'h1234);
        for (int i = 2; i < NSLOTS; i++) send_request(ACT_BLOCK, block_num_t'(i));
        send_request(ACT_BLOCK, 16'h0100);
        send_request(ACT_BUFFER, 16'h0200);
        send_request(ACT_BLOCK, 16'h0003);
        send_request(ACT_UPDATE, 16'h0000);
        send_request(ACT_SAVE, 16'hFFFF);
        send_request(ACT_SAVE, 16'h0000);
        send_request(ACT_UPDATE, 16'h0000);
        send_request(ACT_FLUSH, 16'h8001);
        send_request(ACT_UPDATE, 16'h0000);
        send_request(ACT_BUFFER, 16'h7FFE);
        send_request(ACT_UPDATE, 16'h0000);
        send_request(ACT_EMPTY, 16'hFFFF);
        send_request(ACT_UPDATE, 16'h0000);
        send_request(ACT_RSVD_LO, 16'hAAAA);
        send_request(ACT_RSVD_HI, 16'h5555);
        wait_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 32 == 0) calm = $urandom_range(0, 2) == 0;
            if (n % 60 == 59) wait_until_drained();
            if (n < RANDOM_ITEMS - CALM_TAIL && !calm && $urandom_range(0, 99) < 35)
                idle_for($urandom_range(1, 6));
            send_request(pick_action(), pick_block());
        end

        wait_until_drained();
        repeat (3 * NSLOTS) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected result beats never arrived", sb.pending());
            sb.errors++;
        end

        $display("Ran %0d requests and checked %0d result beats.", sb.requests, sb.beats_seen);
        $display("Lookups hit %0d times; %0d loads and %0d write-backs were predicted.",
                 sb.hits, sb.loads, sb.writebacks);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/lbbc_pkg.sv
src/lbbc_ram.sv
src/lru_block_buffer_cache_core.sv
src/lbbc_checker.sv
bench/tb_lru_block_buffer_cache_core.sv
